### hw/rtl/vif_pkg.sv
// Shared types and constants for the virtual impedance IIR filter.
`default_nettype none

package vif_pkg;

    localparam int C_SAMPLE_W = 16;
    localparam int C_COEF_W   = 24;
    localparam int C_FRAC_W   = 22;
    localparam int C_CFG_IW   = 2;

    // Q2.22 coefficient times a 17-bit current difference or a 16-bit past output
    localparam int C_DIFF_W = C_SAMPLE_W + 1;
    localparam int C_PG_W   = C_COEF_W + C_DIFF_W;
    localparam int C_PF_W   = C_COEF_W + C_SAMPLE_W;
    // three-term sum with headroom
    localparam int C_ACC_W  = C_PG_W + 3;
    localparam int C_RND_W  = C_ACC_W - C_FRAC_W;

    localparam logic signed [C_SAMPLE_W-1:0] C_SAMPLE_MAX = {1'b0, {(C_SAMPLE_W-1){1'b1}}};
    localparam logic signed [C_SAMPLE_W-1:0] C_SAMPLE_MIN = {1'b1, {(C_SAMPLE_W-1){1'b0}}};

    typedef enum logic [C_CFG_IW-1:0] {
        CFG_GAIN   = 2'd0,
        CFG_FB_ONE = 2'd1,
        CFG_FB_TWO = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [C_COEF_W-1:0] gain;
        logic signed [C_COEF_W-1:0] fb_one;
        logic signed [C_COEF_W-1:0] fb_two;
    } t_coefs;

    typedef struct packed {
        logic signed [C_SAMPLE_W-1:0] cur_p1;
        logic signed [C_SAMPLE_W-1:0] cur_p2;
        logic signed [C_SAMPLE_W-1:0] out_p1;
        logic signed [C_SAMPLE_W-1:0] out_p2;
    } t_hist;

    typedef struct packed {
        logic signed [C_SAMPLE_W-1:0] voltage;
        logic                         sat;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/vif_cfg_regs.sv
// Coefficient register file for the virtual impedance IIR filter.
`default_nettype none

module vif_cfg_regs import vif_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_we,
    input  wire logic [C_CFG_IW-1:0] i_addr,
    input  wire logic [C_COEF_W-1:0] i_wdata,
    output t_coefs                   o_coefs
);

    t_coefs r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (i_we) begin
            unique case (i_addr)
                CFG_GAIN:   r_coefs.gain   <= signed'(i_wdata);
                CFG_FB_ONE: r_coefs.fb_one <= signed'(i_wdata);
                CFG_FB_TWO: r_coefs.fb_two <= signed'(i_wdata);
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    assign o_coefs = r_coefs;

endmodule

`default_nettype wire

### hw/rtl/vif_core.sv
// One filter step: products, rounding shift and 16-bit saturation.
`default_nettype none

module vif_core import vif_pkg::*; (
    input  wire logic signed [C_SAMPLE_W-1:0] i_sample,
    input  wire t_hist                        i_hist,
    input  wire t_coefs                       i_coefs,
    output t_result                           o_result
);

    logic signed [C_DIFF_W-1:0] w_diff;
    logic signed [C_PG_W-1:0]   w_prod_g;
    logic signed [C_PF_W-1:0]   w_prod_a1;
    logic signed [C_PF_W-1:0]   w_prod_a2;
    logic signed [C_ACC_W-1:0]  w_acc;
    logic signed [C_ACC_W-1:0]  w_acc_rnd;
    logic signed [C_RND_W-1:0]  w_rnd;
    logic [C_RND_W-C_SAMPLE_W:0] w_top;
    logic                        w_ovf;

    assign w_diff    = C_DIFF_W'(i_sample) - C_DIFF_W'(i_hist.cur_p2);
    assign w_prod_g  = i_coefs.gain * w_diff;
    assign w_prod_a1 = i_coefs.fb_one * i_hist.out_p1;
    assign w_prod_a2 = i_coefs.fb_two * i_hist.out_p2;

    assign w_acc = C_ACC_W'(w_prod_g) - C_ACC_W'(w_prod_a1) - C_ACC_W'(w_prod_a2);

    // round half up, then drop the fraction bits (floor)
    assign w_acc_rnd = w_acc + signed'(C_ACC_W'(1) <<< (C_FRAC_W - 1));
    assign w_rnd     = signed'(w_acc_rnd[C_ACC_W-1:C_FRAC_W]);

    // fits 16 bits only when all bits from the sample sign up agree
    assign w_top = w_rnd[C_RND_W-1:C_SAMPLE_W-1];
    assign w_ovf = !((&w_top) || !(|w_top));

    always_comb begin
        o_result.sat = w_ovf;
        if (!w_ovf) begin
            o_result.voltage = signed'(w_rnd[C_SAMPLE_W-1:0]);
        end else if (w_rnd[C_RND_W-1]) begin
            o_result.voltage = C_SAMPLE_MIN;
        end else begin
            o_result.voltage = C_SAMPLE_MAX;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/virtual_impedance_iir_filter.sv
// Top level of the virtual impedance IIR filter: handshake pipeline and history.
//
//  channel   dir  tdata                        tuser          width
//  s_axis    in   [15:0] current_sample        -              16
//  m_axis    out  [15:0] drop_sample           [0] saturated  16 + 1
//  cfg       in   i_cfg_wdata[23:0] at i_cfg_addr[1:0]        24
//
// One item per cycle sustained while m_axis accepts. Two register stages, input
// register then filter step into the result register: an accepted item waits
// in the input register until the step moves its result into the result
// register that drives m_axis. The v[k-1] feedback closes inside the filter step,
// so the history registers update at the same edge the result is captured.
// Synchronous active-low reset clears coefficients, history and both valids.
// A stall on m_axis holds the result; the input register fills and then
// s_axis_tready drops until the result is taken.
`default_nettype none

module virtual_impedance_iir_filter import vif_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write port
    input  wire logic                  i_cfg_we,
    input  wire logic [C_CFG_IW-1:0]   i_cfg_addr,
    input  wire logic [C_COEF_W-1:0]   i_cfg_wdata,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [C_SAMPLE_W-1:0] s_axis_tdata,   // [15:0] current_sample
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [C_SAMPLE_W-1:0]      m_axis_tdata,   // [15:0] drop_sample
    output logic [0:0]                 m_axis_tuser    // [0] saturated
);

    t_coefs  w_coefs;
    t_result w_result;

    // input register
    logic                         r_in_valid;
    logic signed [C_SAMPLE_W-1:0] r_in_sample;
    // result register
    logic                         r_out_valid;
    t_result                      r_out;
    // filter history
    t_hist                        r_hist;
    t_hist                        n_hist;

    logic w_in_accept;
    logic w_step;

    vif_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_coefs (w_coefs)
    );

    vif_core u_core (
        .i_sample (r_in_sample),
        .i_hist   (r_hist),
        .i_coefs  (w_coefs),
        .o_result (w_result)
    );

    // step runs whenever an item waits and the result slot is free or draining
    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_hist.cur_p1 = r_in_sample;
        n_hist.cur_p2 = r_hist.cur_p1;
        n_hist.out_p1 = w_result.voltage;   // saturated value feeds back
        n_hist.out_p2 = r_hist.out_p1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hist      <= '0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end

            if (w_step) begin
                r_out_valid <= 1'b1;
                r_hist      <= n_hist;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_sample <= signed'(s_axis_tdata);
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.voltage;
    assign m_axis_tuser  = r_out.sat;

endmodule

`default_nettype wire

### hw/rtl/vif_checker.sv
// Port-level assertions for the virtual impedance IIR filter, bound to the top.
`default_nettype none

module vif_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // clip flag only on a range bound
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8000)
        else $error("saturated flag on an unclipped value");

    // input side blocks only behind a pending result
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with result slot free");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind virtual_impedance_iir_filter vif_checker u_vif_checker (.*);

`default_nettype wire

### verif/tb_virtual_impedance_iir_filter.sv
// Self-checking testbench for the virtual impedance IIR filter.
`timescale 1ns / 1ps

module tb_virtual_impedance_iir_filter;
    import vif_pkg::*;

    // run shape
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int SETTLE_CYCLES   = 4;        // pipeline is two deep, leave margin
    localparam int DRAIN_CYCLES    = 8;
    localparam int TIMEOUT_NS      = 1_000_000;

    // address 3 decodes to no register; writes there must be dropped
    localparam logic [C_CFG_IW-1:0] CFG_SPARE = 2'd3;

    // handy Q2.22 values
    localparam logic [C_COEF_W-1:0] Q_ONE     = 24'h400000;
    localparam logic [C_COEF_W-1:0] Q_HALF    = 24'h200000;
    localparam logic [C_COEF_W-1:0] Q_MAX     = 24'h7FFFFF;
    localparam logic [C_COEF_W-1:0] Q_MIN     = 24'h800000;
    localparam int                  Q_ONE_INT = 4194304;

    typedef enum logic [1:0] {
        ROW_WRITE,      // register write, block drained first
        ROW_CHECK,      // item with the result typed in the row
        ROW_PREDICT     // item checked against the predictor
    } t_row_kind;

    typedef struct packed {
        t_row_kind                   kind;
        logic [C_CFG_IW-1:0]         addr;
        logic [C_COEF_W-1:0]         value;
        logic [C_SAMPLE_W-1:0]       sample;
        logic [C_SAMPLE_W-1:0]       exp_volt;
        logic                        exp_sat;
    } t_stim_row;

    // Directed part. Typed results follow from history being zero after reset:
    // zero coefficients give zero, unity gain with no feedback gives
    // i[k] - i[k-2], and half gain shows ties going toward plus infinity.
    localparam int N_DIR_ROWS = 30;
    localparam t_stim_row DIR_ROWS [N_DIR_ROWS] = '{
        '{ROW_CHECK,   CFG_GAIN,   24'h0,  16'h7FFF, 16'h0000, 1'b0},
        '{ROW_CHECK,   CFG_GAIN,   24'h0,  16'h8000, 16'h0000, 1'b0},
        '{ROW_CHECK,   CFG_GAIN,   24'h0,  16'h0000, 16'h0000, 1'b0},
        '{ROW_CHECK,   CFG_GAIN,   24'h0,  16'h0000, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_GAIN,   Q_ONE,  16'h0000, 16'h0000, 1'b0},
        '{ROW_CHECK,   CFG_GAIN,   24'h0,  16'h7FFF, 16'h7FFF, 1'b0},
        '{ROW_CHECK,   CFG_GAIN,   24'h0,  16'h8000, 16'h8000, 1'b0},
        '{ROW_CHECK,   CFG_GAIN,   24'h0,  16'h8000, 16'h8000, 1'b1},  // -65535 clips low
        '{ROW_CHECK,   CFG_GAIN,   24'h0,  16'h7FFF, 16'h7FFF, 1'b1},  // +65535 clips high
        '{ROW_WRITE,   CFG_SPARE,  Q_MAX,  16'h0000, 16'h0000, 1'b0},  // must be ignored
        '{ROW_CHECK,   CFG_GAIN,   24'h0,  16'h0000, 16'h7FFF, 1'b1},  // 0 - (-32768)
        '{ROW_WRITE,   CFG_FB_ONE, Q_MIN,  16'h0000, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_GAIN,   24'h0,  16'h0064, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_GAIN,   24'h0,  16'hFF9C, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_GAIN,   24'h0,  16'h0001, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_FB_TWO, Q_MAX,  16'h0000, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_GAIN,   Q_MIN,  16'h0000, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_GAIN,   24'h0,  16'h3039, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_GAIN,   24'h0,  16'hFFFF, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_GAIN,   24'h0,  16'h5555, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_GAIN,   24'h0,  16'hAAAA, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_FB_ONE, 24'h0,  16'h0000, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_FB_TWO, 24'h0,  16'h0000, 16'h0000, 1'b0},
        '{ROW_WRITE,   CFG_GAIN,   Q_HALF, 16'h0000, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_GAIN,   24'h0,  16'h0000, 16'h0000, 1'b0},
        '{ROW_PREDICT, CFG_GAIN,   24'h0,  16'h0000, 16'h0000, 1'b0},
        '{ROW_CHECK,   CFG_GAIN,   24'h0,  16'h0001, 16'h0001, 1'b0},  // +0.5 -> 1
        '{ROW_CHECK,   CFG_GAIN,   24'h0,  16'hFFFF, 16'h0000, 1'b0},  // -0.5 -> 0
        '{ROW_CHECK,   CFG_GAIN,   24'h0,  16'h0000, 16'h0000, 1'b0},  // -0.5 -> 0
        '{ROW_CHECK,   CFG_GAIN,   24'h0,  16'h0000, 16'h0001, 1'b0}   // +0.5 -> 1
    };

    // ---------------------------------------------------------------- DUT I/O
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [C_CFG_IW-1:0]   i_cfg_addr    = '0;
    logic [C_COEF_W-1:0]   i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [C_SAMPLE_W-1:0] s_axis_tdata  = '0;    // [15:0] current_sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [C_SAMPLE_W-1:0] m_axis_tdata;          // [15:0] drop_sample
    logic [0:0]            m_axis_tuser;          // [0] saturated

    virtual_impedance_iir_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------ predictor
    t_coefs  filt_coefs = '0;
    t_hist   filt_hist  = '0;
    t_result pending_drops [$];   // voltage drops owed by the block, oldest first
    int      error_count = 0;

    // One filter step: exact product sum, round half up at bit 22, clip to 16 bits.
    // The clipped value goes into the output history.
    function automatic t_result predict_drop(input logic signed [C_SAMPLE_W-1:0] cur);
        longint  acc;
        longint  rnd;
        t_result res;
        acc = longint'($signed(filt_coefs.gain))
                  * (longint'(cur) - longint'($signed(filt_hist.cur_p2)))
            - longint'($signed(filt_coefs.fb_one)) * longint'($signed(filt_hist.out_p1))
            - longint'($signed(filt_coefs.fb_two)) * longint'($signed(filt_hist.out_p2));
        rnd = (acc + (longint'(1) <<< (C_FRAC_W - 1))) >>> C_FRAC_W;
        res.sat = 1'b0;
        if (rnd > longint'(C_SAMPLE_MAX)) begin
            res.voltage = C_SAMPLE_MAX;
            res.sat     = 1'b1;
        end else if (rnd < longint'(C_SAMPLE_MIN)) begin
            res.voltage = C_SAMPLE_MIN;
            res.sat     = 1'b1;
        end else begin
            res.voltage = rnd[C_SAMPLE_W-1:0];
        end
        filt_hist.cur_p2 = filt_hist.cur_p1;
        filt_hist.cur_p1 = cur;
        filt_hist.out_p2 = filt_hist.out_p1;
        filt_hist.out_p1 = res.voltage;
        return res;
    endfunction

    // Coefficient write. Only done with the block empty: input dropped, every
    // owed result drained, then a wait for the pipeline to settle.
    task automatic write_coef(input logic [C_CFG_IW-1:0] idx,
                              input logic [C_COEF_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending_drops.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_GAIN:   filt_coefs.gain   = val;
            CFG_FB_ONE: filt_coefs.fb_one = val;
            CFG_FB_TWO: filt_coefs.fb_two = val;
            default: ;  // spare address, nothing changes
        endcase
    endtask

    // Offer one current sample and hold it until taken. Valid is left high so
    // back-to-back items follow without a gap; the caller lowers it for a gap.
    // A typed result, where given, replaces the predicted one in the queue, but
    // the predictor still steps so its history stays in line.
    task automatic offer_current(input logic [C_SAMPLE_W-1:0] x,
                                 input bit                    typed,
                                 input t_result               typed_res);
        t_result res;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        do @(posedge i_clk); while (!s_axis_tready);
        res = predict_drop(x);
        if (typed)
            res = typed_res;
        pending_drops.push_back(res);
    endtask

    // --------------------------------------------------------------- checker
    // Handshake sampled at the edge, before this edge's updates land.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_drops.size() == 0) begin
                $error("drop_sample: unexpected item, got %0d (saturated %0b)",
                       $signed(m_axis_tdata), m_axis_tuser[0]);
                error_count++;
            end else begin
                want = pending_drops.pop_front();
                if (m_axis_tdata !== want.voltage) begin
                    $error("drop_sample: expected %0d, got %0d",
                           $signed(want.voltage), $signed(m_axis_tdata));
                    error_count++;
                end
                if (m_axis_tuser[0] !== want.sat) begin
                    $error("saturated: expected %0b, got %0b", want.sat, m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // -------------------------------------------------------------- receiver
    // Segments of random duty, of steady ready, and now and then a long hold
    // so the two-deep pipe fills and input ready drops while items are offered.
    initial begin
        int seg;
        int len;
        int duty;
        seg = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (seg == 2 || $urandom_range(0, 15) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(40, 80)) @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(10, 100)) @(posedge i_clk);
            end else begin
                len  = $urandom_range(10, 100);
                duty = $urandom_range(10, 90);
                repeat (len) begin
                    m_axis_tready <= ($urandom_range(0, 99) < duty);
                    @(posedge i_clk);
                end
            end
            seg++;
        end
    end

    // -------------------------------------------------------------- stimulus
    initial begin
        t_stim_row             row;
        t_result               typed_res;
        logic [C_COEF_W-1:0]   new_coef [3];
        logic [C_SAMPLE_W-1:0] cur;
        int                    burst_left;
        int                    pick;
        int                    a2_int;
        int                    lim;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < N_DIR_ROWS; r++) begin
            row = DIR_ROWS[r];
            typed_res.voltage = row.exp_volt;
            typed_res.sat     = row.exp_sat;
            case (row.kind)
                ROW_WRITE:   write_coef(row.addr, row.value);
                ROW_CHECK:   offer_current(row.sample, 1'b1, typed_res);
                ROW_PREDICT: offer_current(row.sample, 1'b0, '0);
                default: ;
            endcase
        end

        // random phases, each with its own coefficient set
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                1: new_coef = '{Q_MAX, Q_MAX, Q_MAX};
                4: new_coef = '{Q_MIN, Q_MIN, Q_MIN};
                2: for (int k = 0; k < 3; k++)
                       new_coef[k] = C_COEF_W'($urandom());
                5: for (int k = 0; k < 3; k++)
                       case ($urandom_range(0, 4))
                           0: new_coef[k] = Q_MIN;
                           1: new_coef[k] = Q_MAX;
                           2: new_coef[k] = '0;
                           3: new_coef[k] = C_COEF_W'(-Q_ONE_INT);
                           default: new_coef[k] = Q_ONE;
                       endcase
                default: begin
                    // stable pole pair: |a2| < 1 and |a1| < 1 + a2, with margin
                    new_coef[CFG_GAIN] = C_COEF_W'(int'($urandom_range(0, Q_ONE_INT))
                                                   - Q_ONE_INT / 2);
                    a2_int = $urandom_range(0, (Q_ONE_INT / 20) * 19);
                    lim    = ((Q_ONE_INT + a2_int) / 10) * 9;
                    new_coef[CFG_FB_ONE] = C_COEF_W'(int'($urandom_range(0, 2 * lim)) - lim);
                    new_coef[CFG_FB_TWO] = C_COEF_W'(a2_int);
                end
            endcase
            for (int k = 0; k < 3; k++)
                write_coef(C_CFG_IW'(k), new_coef[k]);
            if ($urandom_range(0, 1) == 1)
                write_coef(CFG_SPARE, C_COEF_W'($urandom()));

            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // halfway through, hold the input until the block has emptied
                if (n == ITEMS_PER_PHASE / 2) begin
                    s_axis_tvalid <= 1'b0;
                    while (pending_drops.size() != 0) @(posedge i_clk);
                    @(posedge i_clk);
                end else if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 64);
                    if ($urandom_range(0, 3) != 0) begin
                        s_axis_tvalid <= 1'b0;
                        repeat ($urandom_range(1, 8)) @(posedge i_clk);
                    end
                end
                if (burst_left > 0)
                    burst_left--;

                // mostly full range, with small values and the rails mixed in
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    cur = C_SAMPLE_W'($urandom());
                else if (pick < 8)
                    cur = C_SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
                else if (pick == 8)
                    cur = ($urandom_range(0, 1) == 1) ? C_SAMPLE_MAX : C_SAMPLE_MIN;
                else
                    cur = C_SAMPLE_W'(int'($urandom_range(0, 2)) - 1);
                offer_current(cur, 1'b0, '0);
            end
        end

        // drain and let the pipe go quiet before the verdict
        s_axis_tvalid <= 1'b0;
        while (pending_drops.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial begin
        #TIMEOUT_NS;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
